FILE: sv/alamouti_2x1_combiner_defines.svh
// Assertion macros used by the combiner top module
`ifndef ALAMOUTI_2X1_COMBINER_DEFINES_SVH
`define ALAMOUTI_2X1_COMBINER_DEFINES_SVH

`ifndef SYNTH
`define ACMB_ASSERT_NOW(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("combiner assertion failed");
`define ACMB_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("combiner assertion failed");
`else
`define ACMB_ASSERT_NOW(lbl, clk, rst_n, a, c)
`define ACMB_ASSERT_NEXT(lbl, clk, rst_n, a, c)
`endif

`endif

FILE: sv/acmb_pkg.sv
package acmb_pkg;

    localparam int IN_W   = 16;
    localparam int PROD_W = 32;
    localparam int NUM_W  = 34;
    localparam int G_W    = 33;
    localparam int MAG_W  = 33;
    localparam int DEN_W  = 34;
    localparam int FRAC_SHIFT = 12;
    localparam int QBITS  = 17;
    localparam int REM_W  = DEN_W + QBITS + 1;
    localparam int FRONT_LAT = 2;
    localparam int LANE_LAT  = QBITS + 3;
    localparam int TOTAL_LAT = FRONT_LAT + LANE_LAT;
    localparam logic [15:0] OUT_MAX = 16'h7FFF;
    localparam logic [15:0] OUT_MIN = 16'h8000;

    typedef logic signed [IN_W-1:0]   samp_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [NUM_W-1:0]  num_t;
    typedef logic [G_W-1:0]           gain_t;

endpackage

FILE: sv/acmb_front.sv
module acmb_front
(
    input  logic                  clk,
    input  logic                  en,
    input  acmb_pkg::samp_t       h0_re,
    input  acmb_pkg::samp_t       h0_im,
    input  acmb_pkg::samp_t       h1_re,
    input  acmb_pkg::samp_t       h1_im,
    input  acmb_pkg::samp_t       r0_re,
    input  acmb_pkg::samp_t       r0_im,
    input  acmb_pkg::samp_t       r1_re,
    input  acmb_pkg::samp_t       r1_im,
    output acmb_pkg::gain_t       g,
    output acmb_pkg::num_t        num [4]
);

    acmb_pkg::prod_t p_reg [4][4];
    acmb_pkg::prod_t sq_reg [4];
    acmb_pkg::gain_t g_reg;
    acmb_pkg::num_t  num_reg [4];
    acmb_pkg::samp_t hv [4];
    acmb_pkg::samp_t rv [4];
    acmb_pkg::num_t  e [4][4];

    assign hv[0] = h0_re;
    assign hv[1] = h0_im;
    assign hv[2] = h1_re;
    assign hv[3] = h1_im;
    assign rv[0] = r0_re;
    assign rv[1] = r0_im;
    assign rv[2] = r1_re;
    assign rv[3] = r1_im;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int a = 0; a < 4; a++)
            begin
                sq_reg[a] <= hv[a] * hv[a];
                for (int b = 0; b < 4; b++)
                begin
                    p_reg[a][b] <= hv[a] * rv[b];
                end
            end
        end
    end

    always_comb
    begin
        for (int a = 0; a < 4; a++)
        begin
            for (int b = 0; b < 4; b++)
            begin
                e[a][b] = acmb_pkg::num_t'(p_reg[a][b]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g_reg <= {2'b00, sq_reg[0][30:0]} + {2'b00, sq_reg[1][30:0]}
                   + {2'b00, sq_reg[2][30:0]} + {2'b00, sq_reg[3][30:0]};
            num_reg[0] <= e[0][0] + e[1][1] + e[2][2] + e[3][3];
            num_reg[1] <= e[0][1] - e[1][0] + e[3][2] - e[2][3];
            num_reg[2] <= e[2][0] + e[3][1] - e[0][2] - e[1][3];
            num_reg[3] <= e[2][1] - e[3][0] - e[1][2] + e[0][3];
        end
    end

    assign g   = g_reg;
    assign num = num_reg;

endmodule

FILE: sv/acmb_lane.sv
module acmb_lane
(
    input  logic                clk,
    input  logic                en,
    input  acmb_pkg::num_t      num,
    input  acmb_pkg::gain_t     g,
    output logic [15:0]         sym,
    output logic                clip
);

    localparam int RW = acmb_pkg::REM_W;
    localparam int QB = acmb_pkg::QBITS;

    logic                          neg_a_reg;
    logic [acmb_pkg::MAG_W-1:0]    mag_a_reg;
    acmb_pkg::gain_t               g_a_reg;
    logic [RW-1:0]                 d_val;
    logic [RW-1:0]                 rem_reg [QB+1];
    logic [acmb_pkg::DEN_W-1:0]    den_reg [QB+1];
    logic [QB-1:0]                 q_reg [QB+1];
    logic                          neg_reg [QB+1];
    logic                          ovf_reg [QB+1];
    logic [15:0]                   sym_reg;
    logic                          clip_reg;
    logic [acmb_pkg::DEN_W-1:0]    den_b;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg_a_reg <= num[acmb_pkg::NUM_W-1];
            mag_a_reg <= num[acmb_pkg::NUM_W-1] ? acmb_pkg::MAG_W'(-num)
                                                  : acmb_pkg::MAG_W'(num);
            g_a_reg   <= g;
        end
    end

    assign den_b = {1'b0, g_a_reg} << 1;
    assign d_val = RW'({mag_a_reg, {acmb_pkg::FRAC_SHIFT{1'b0}}}) + RW'(g_a_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= d_val;
            den_reg[0] <= den_b;
            q_reg[0]   <= '0;
            neg_reg[0] <= neg_a_reg;
            ovf_reg[0] <= d_val >= (RW'(den_b) << QB);
        end
    end

    for (genvar k = 0; k < QB; k++)
    begin : g_step
        localparam int BIT = QB - 1 - k;
        logic [RW-1:0] shd;
        logic          take;
        assign shd  = RW'(den_reg[k]) << BIT;
        assign take = rem_reg[k] >= shd;
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1] <= take ? rem_reg[k] - shd : rem_reg[k];
                q_reg[k+1]   <= q_reg[k] | (QB'(take) << BIT);
                den_reg[k+1] <= den_reg[k];
                neg_reg[k+1] <= neg_reg[k];
                ovf_reg[k+1] <= ovf_reg[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (neg_reg[QB])
            begin
                if (ovf_reg[QB] || q_reg[QB] > QB'(32768))
                begin
                    sym_reg  <= acmb_pkg::OUT_MIN;
                    clip_reg <= 1'b1;
                end
                else
                begin
                    sym_reg  <= ~q_reg[QB][15:0] + 16'd1;
                    clip_reg <= 1'b0;
                end
            end
            else
            begin
                if (ovf_reg[QB] || q_reg[QB] > QB'(32767))
                begin
                    sym_reg  <= acmb_pkg::OUT_MAX;
                    clip_reg <= 1'b1;
                end
                else
                begin
                    sym_reg  <= q_reg[QB][15:0];
                    clip_reg <= 1'b0;
                end
            end
        end
    end

    assign sym  = sym_reg;
    assign clip = clip_reg;

endmodule

FILE: sv/alamouti_2x1_combiner.sv
// Throughput: one transaction per cycle while the output is not stalled; the
// restoring divider retires one quotient bit per stage in each of four lanes,
// 17 stages deep.
// Reset: rst_n clears only the valid bits; data registers are not reset.
// A stalled output holds the whole pipeline.
`include "alamouti_2x1_combiner_defines.svh"

module alamouti_2x1_combiner
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic signed [15:0]  h0_re,
    input  logic signed [15:0]  h0_im,
    input  logic signed [15:0]  h1_re,
    input  logic signed [15:0]  h1_im,
    input  logic signed [15:0]  r0_re,
    input  logic signed [15:0]  r0_im,
    input  logic signed [15:0]  r1_re,
    input  logic signed [15:0]  r1_im,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [15:0]  sym0_re,
    output logic signed [15:0]  sym0_im,
    output logic signed [15:0]  sym1_re,
    output logic signed [15:0]  sym1_im,
    output logic                zero_gain,
    output logic                clipped
);

    localparam int TL = acmb_pkg::TOTAL_LAT;
    localparam int LL = acmb_pkg::LANE_LAT;

    logic            en;
    logic [TL-1:0]   vld_reg;
    logic [LL-1:0]   zero_reg;
    acmb_pkg::gain_t g;
    acmb_pkg::num_t  num [4];
    logic [15:0]     sym [4];
    logic [3:0]      clip;

    assign en       = !(vld_reg[TL-1] && out_stall);
    assign in_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[TL-2:0], in_valid};
        end
    end

    acmb_front u_front
    (
        .clk   (clk),
        .en    (en),
        .h0_re (h0_re),
        .h0_im (h0_im),
        .h1_re (h1_re),
        .h1_im (h1_im),
        .r0_re (r0_re),
        .r0_im (r0_im),
        .r1_re (r1_re),
        .r1_im (r1_im),
        .g     (g),
        .num   (num)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zero_reg <= {zero_reg[LL-2:0], g == '0};
        end
    end

    for (genvar i = 0; i < 4; i++)
    begin : g_lane
        acmb_lane u_lane
        (
            .clk  (clk),
            .en   (en),
            .num  (num[i]),
            .g    (g),
            .sym  (sym[i]),
            .clip (clip[i])
        );
    end

    assign out_valid = vld_reg[TL-1];
    assign zero_gain = zero_reg[LL-1];
    assign sym0_re   = zero_gain ? '0 : sym[0];
    assign sym0_im   = zero_gain ? '0 : sym[1];
    assign sym1_re   = zero_gain ? '0 : sym[2];
    assign sym1_im   = zero_gain ? '0 : sym[3];
    assign clipped   = !zero_gain && (|clip);

    `ACMB_ASSERT_NOW(a_stall_cause, clk, rst_n, in_stall, out_valid && out_stall)
    `ACMB_ASSERT_NEXT(a_enter, clk, rst_n, in_valid && !in_stall, vld_reg[0])
    `ACMB_ASSERT_NOW(a_zero_out, clk, rst_n, out_valid && zero_gain, !clipped && sym0_re == '0)

endmodule
